/* hdl/snowpack_density_update_assert.svh */
// Assertion macros shared by the snowpack density checker
`ifndef SNOWPACK_DENSITY_UPDATE_ASSERT_SVH
`define SNOWPACK_DENSITY_UPDATE_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define SPD_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SPD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/spd_pkg.sv */
// Shared constants and types for the snowpack density update pipeline
package spd_pkg;

  // fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int WORK_BITS = 30;

  // field widths
  localparam int DENS_W = 26;
  localparam int WE_W   = 32;
  localparam int RIN_W  = 24;
  localparam int TEMP_W = 17;
  localparam int COEF_W = 16;

  // exponential unit: Taylor terms, squarings, latency
  localparam int TERMS   = 12;
  localparam int SQUARES = 5;
  localparam int EXP_LAT = 1 + 3 * TERMS + 2 + SQUARES + 1;
  localparam int EXP_X_W = 25;
  localparam int EXP_E_W = FRAC_BITS + 1;

  // mass-weighted division
  localparam int SUM_W = WE_W + 1;
  localparam int NUM_W = 60;
  localparam int QUO_W = 27;

  // 273.15 K in Q9.8
  localparam logic [TEMP_W-1:0] KELVIN_Q8 = 17'd69926;

  // configuration register map
  typedef enum logic [1:0] {
    REG_FRESH = 2'd0,
    REG_MAX   = 2'd1,
    REG_SENS  = 2'd2,
    REG_BASE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic             valid;
    logic [QUO_W-1:0] quo;
    logic [SUM_W-1:0] den;
  } div_out_t;

endpackage

/* hdl/spd_exp.sv */
// Pipelined exp(-x) unit: Taylor series with constant-reciprocal division, then squarings
module spd_exp import spd_pkg::*; (
  input  logic               clk,
  input  logic               adv,
  input  logic [EXP_X_W-1:0] x,
  output logic [EXP_E_W-1:0] e
);

  localparam int WB = WORK_BITS;

  // floor(2^31 / k) for k = 1..12
  localparam logic [31:0] RECIP [TERMS] = '{
    32'd2147483648, 32'd1073741824, 32'd715827882, 32'd536870912,
    32'd429496729,  32'd357913941,  32'd306783378, 32'd268435456,
    32'd238609294,  32'd214748364,  32'd195225786, 32'd178956970
  };

  typedef struct packed {
    logic          z;
    logic [WB-1:0] y;
    logic [WB:0]   val;
    logic [WB:0]   aux;
    logic [WB+1:0] pos;
    logic [WB+1:0] neg;
  } est_t;

  typedef struct packed {
    logic        z;
    logic [WB:0] r;
  } sq_t;

  est_t s0_r, s0_nxt;
  est_t sa_r [TERMS];
  est_t sb_r [TERMS];
  est_t sc_r [TERMS];
  est_t f1_r, f1_nxt;
  est_t f2_r, f2_nxt;
  sq_t  sq_r [SQUARES];
  logic [EXP_E_W-1:0] e_r, e_nxt;
  logic [WB:0]        rnd;

  // entry: flush flag, argument scaled to Q.30 and divided by 32
  always_comb begin
    s0_nxt     = '0;
    s0_nxt.z   = x > (EXP_X_W'(16) << FRAC_BITS);
    s0_nxt.y   = WB'(x) << (WB - FRAC_BITS - 5);
    s0_nxt.val = (WB+1)'(1) << WB;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= s0_nxt;
    end
  end

  // one Taylor term per three stages: multiply, reciprocal multiply, correct
  for (genvar g = 0; g < TERMS; g++) begin : g_term
    est_t prv, a_nxt, b_nxt, c_nxt;
    logic [2*WB:0]  prod;
    logic [WB+32:0] rprod;
    logic [WB+1:0]  back;
    logic [WB+1:0]  rem;

    if (g == 0) begin : g_first
      assign prv = s0_r;
    end else begin : g_next
      assign prv = sc_r[g-1];
    end

    // term * y, and fold the previous term into its sum
    always_comb begin
      a_nxt     = prv;
      prod      = (2*WB+1)'(prv.val) * (2*WB+1)'(prv.y);
      a_nxt.val = prod[2*WB:WB];
      if ((g % 2) == 0) begin
        a_nxt.pos = prv.pos + (WB+2)'(prv.val);
      end else begin
        a_nxt.neg = prv.neg + (WB+2)'(prv.val);
      end
    end

    // quotient estimate, low by at most one
    always_comb begin
      b_nxt     = sa_r[g];
      rprod     = (WB+33)'(sa_r[g].val) * (WB+33)'(RECIP[g]);
      b_nxt.aux = rprod[WB+31:31];
    end

    // remainder check
    always_comb begin
      c_nxt     = sb_r[g];
      back      = (WB+2)'(sb_r[g].aux) * (WB+2)'(g + 1);
      rem       = (WB+2)'(sb_r[g].val) - back;
      c_nxt.val = sb_r[g].aux + (WB+1)'(rem >= (WB+2)'(g + 1));
      c_nxt.aux = '0;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sa_r[g] <= a_nxt;
        sb_r[g] <= b_nxt;
        sc_r[g] <= c_nxt;
      end
    end
  end

  // last term into its sum, then the difference of sums
  always_comb begin
    f1_nxt = sc_r[TERMS-1];
    if ((TERMS % 2) == 0) begin
      f1_nxt.pos = sc_r[TERMS-1].pos + (WB+2)'(sc_r[TERMS-1].val);
    end else begin
      f1_nxt.neg = sc_r[TERMS-1].neg + (WB+2)'(sc_r[TERMS-1].val);
    end
    f2_nxt     = f1_r;
    f2_nxt.val = (WB+1)'(f1_r.pos - f1_r.neg);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
    end
  end

  // repeated squaring with rounding undoes the divide by 32
  for (genvar i = 0; i < SQUARES; i++) begin : g_sq
    sq_t prv, nxt;
    logic [2*WB+1:0] sqp;

    if (i == 0) begin : g_first
      assign prv.z = f2_r.z;
      assign prv.r = f2_r.val;
    end else begin : g_next
      assign prv = sq_r[i-1];
    end

    always_comb begin
      sqp   = (2*WB+2)'(prv.r) * (2*WB+2)'(prv.r) + ((2*WB+2)'(1) << (WB - 1));
      nxt.z = prv.z;
      nxt.r = sqp[2*WB:WB];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[i] <= nxt;
      end
    end
  end

  // round to Q.16, flush large arguments
  always_comb begin
    rnd   = sq_r[SQUARES-1].r + ((WB+1)'(1) << (WB - FRAC_BITS - 1));
    e_nxt = sq_r[SQUARES-1].z ? '0 : rnd[WB -: EXP_E_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r <= e_nxt;
    end
  end

  assign e = e_r;

endmodule

/* hdl/spd_div.sv */
// Pipelined restoring divider, one quotient bit per stage
module spd_div import spd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  div_in_t  din,
  output div_out_t dout
);

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [QUO_W-1:0] quo;
    logic [SUM_W-1:0] den;
  } dst_t;

  dst_t st_r [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_bit
    localparam int B = QUO_W - 1 - i;
    dst_t         prv, nxt;
    logic [SUM_W:0] t;
    logic           ge;

    // quotient fits QUO_W bits, so the top numerator bits start below den
    if (i == 0) begin : g_first
      always_comb begin
        prv       = '0;
        prv.valid = din.valid;
        prv.rem   = din.num[NUM_W-1:QUO_W];
        prv.num   = din.num;
        prv.den   = din.den;
      end
    end else begin : g_next
      assign prv = st_r[i-1];
    end

    // shift in one numerator bit, subtract when it fits
    always_comb begin
      nxt      = prv;
      t        = {prv.rem, prv.num[B]};
      ge       = t >= {1'b0, prv.den};
      nxt.rem  = ge ? SUM_W'(t - {1'b0, prv.den}) : t[SUM_W-1:0];
      nxt.quo[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[i].valid <= 1'b0;
      end else if (adv) begin
        st_r[i] <= nxt;
      end
    end
  end

  assign dout.valid = st_r[QUO_W-1].valid;
  assign dout.quo   = st_r[QUO_W-1].quo;
  assign dout.den   = st_r[QUO_W-1].den;

endmodule

/* hdl/snowpack_density_update.sv */
// Snowpack density update top level: config registers, arithmetic pipeline, output stage
// The pipeline has 127 register stages: two 45-stage exp units, a 27-stage divider
// and 10 arithmetic/output stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n, synchronous, active low) clears valid bits and loads register
// defaults; no memory, no clearing pass.
module snowpack_density_update import spd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RIN_W-1:0]  in_snowfall_rate,
  input  logic [RIN_W-1:0]  in_step_days,
  input  logic [TEMP_W-1:0] in_skin_temp_kelvin,
  input  logic [WE_W-1:0]   in_old_water_equiv,
  input  logic [DENS_W-1:0] in_old_density,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WE_W-1:0]   out_new_water_equiv,
  output logic [DENS_W-1:0] out_new_density,
  output logic              out_mass_saturated,
  output logic              out_bare_ground,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  typedef struct packed {
    logic              valid;
    logic [RIN_W-1:0]  snow;
    logic [RIN_W-1:0]  step;
    logic [TEMP_W-1:0] tk;
    logic [WE_W-1:0]   swe;
    logic [DENS_W-1:0] rho;
  } p1_t;

  typedef struct packed {
    logic              valid;
    logic [RIN_W-1:0]  step;
    logic [WE_W-1:0]   swe;
    logic [DENS_W-1:0] rho;
    logic [TEMP_W-1:0] tc;
    logic [WE_W-1:0]   added;
  } p2_t;

  typedef struct packed {
    logic              valid;
    logic [RIN_W-1:0]  step;
    logic [DENS_W-1:0] diff;
    logic              dneg;
    logic [WE_W-1:0]   swe;
    logic [WE_W-1:0]   added;
    logic [SUM_W-1:0]  sum;
  } side_t;

  typedef struct packed {
    logic                     valid;
    logic [WE_W+DENS_W-1:0]   prod_a;
    logic [WE_W+DENS_W-1:0]   prod_b;
    logic [SUM_W-1:0]         sum;
  } q3_t;

  // configuration registers
  logic [DENS_W-1:0] fresh_r, max_r;
  logic [COEF_W-1:0] sens_r, base_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  // pipeline registers
  p1_t   p1_r, p1_nxt;
  p2_t   p2_r, p2_nxt;
  side_t p3_r, p3_nxt;
  logic [EXP_X_W-1:0] a1_r, a1_nxt;
  side_t d1_r [EXP_LAT];
  side_t p4_r;
  logic [COEF_W-1:0]  rate_r, rate_nxt;
  side_t p5_r;
  logic [EXP_X_W-1:0] a2_r, a2_nxt;
  side_t d2_r [EXP_LAT];
  side_t q1_r;
  logic [DENS_W-1:0]  delta_r, delta_nxt;
  side_t q2_r;
  logic [DENS_W-1:0]  comp_r, comp_nxt;
  q3_t     q3_r, q3_nxt;
  div_in_t q4_r, q4_nxt;
  div_out_t dq;

  logic [EXP_E_W-1:0] e1, e2;
  logic               adv;

  logic [2*RIN_W-1:0]          snow_prod;
  logic [COEF_W+TEMP_W:0]      a1_full;
  logic [COEF_W+EXP_E_W:0]     rate_full;
  logic [COEF_W+RIN_W-1:0]     a2_full;
  logic [DENS_W+EXP_E_W:0]     delta_full;

  // output stage
  logic              out_valid_r;
  logic [WE_W-1:0]   swe_out_r, swe_out_nxt;
  logic [DENS_W-1:0] dens_r, dens_nxt;
  logic              sat_r, sat_nxt;
  logic              bare_r, bare_nxt;
  logic [QUO_W-1:0]  dsel, dmax;

  // whole pipeline moves unless a result is held
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= DENS_W'(6553600);
      max_r   <= DENS_W'(19660800);
      sens_r  <= COEF_W'(5243);
      base_r  <= COEF_W'(6554);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRESH: fresh_r <= cfg_pwdata[DENS_W-1:0];
        REG_MAX:   max_r   <= cfg_pwdata[DENS_W-1:0];
        REG_SENS:  sens_r  <= cfg_pwdata[COEF_W-1:0];
        REG_BASE:  base_r  <= cfg_pwdata[COEF_W-1:0];
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_FRESH: cfg_prdata = 32'(fresh_r);
      REG_MAX:   cfg_prdata = 32'(max_r);
      REG_SENS:  cfg_prdata = 32'(sens_r);
      REG_BASE:  cfg_prdata = 32'(base_r);
    endcase
  end

  // ---------------- front stages ----------------
  // stage 1: capture the transfer
  always_comb begin
    p1_nxt.valid = in_valid;
    p1_nxt.snow  = in_snowfall_rate;
    p1_nxt.step  = in_step_days;
    p1_nxt.tk    = in_skin_temp_kelvin;
    p1_nxt.swe   = in_old_water_equiv;
    p1_nxt.rho   = in_old_density;
  end

  // stage 2: density floor, Celsius magnitude, new snow mass
  always_comb begin
    p2_nxt.valid = p1_r.valid;
    p2_nxt.step  = p1_r.step;
    p2_nxt.swe   = p1_r.swe;
    p2_nxt.rho   = (p1_r.rho < fresh_r) ? fresh_r : p1_r.rho;
    p2_nxt.tc    = (p1_r.tk < KELVIN_Q8) ? (KELVIN_Q8 - p1_r.tk) : '0;
    snow_prod    = (2*RIN_W)'(p1_r.snow) * (2*RIN_W)'(p1_r.step);
    p2_nxt.added = snow_prod[FRAC_BITS +: WE_W];
  end

  // stage 3: first exp argument, mass sum, distance to maximum
  always_comb begin
    a1_full      = (COEF_W+TEMP_W+1)'(sens_r) * (COEF_W+TEMP_W+1)'(p2_r.tc)
                 + (COEF_W+TEMP_W+1)'(128);
    a1_nxt       = a1_full[8 +: EXP_X_W];
    p3_nxt.valid = p2_r.valid;
    p3_nxt.step  = p2_r.step;
    p3_nxt.swe   = p2_r.swe;
    p3_nxt.added = p2_r.added;
    p3_nxt.sum   = SUM_W'(p2_r.swe) + SUM_W'(p2_r.added);
    p3_nxt.dneg  = max_r < p2_r.rho;
    p3_nxt.diff  = p3_nxt.dneg ? (p2_r.rho - max_r) : (max_r - p2_r.rho);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.valid <= 1'b0;
      p2_r.valid <= 1'b0;
      p3_r.valid <= 1'b0;
    end else if (adv) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
      a1_r <= a1_nxt;
    end
  end

  // ---------------- temperature term ----------------
  spd_exp u_exp1 (
    .clk (clk),
    .adv (adv),
    .x   (a1_r),
    .e   (e1)
  );

  // rate and second exp argument
  always_comb begin
    rate_full = (COEF_W+EXP_E_W+1)'(base_r) * (COEF_W+EXP_E_W+1)'(e1)
              + (COEF_W+EXP_E_W+1)'(1 << (FRAC_BITS - 1));
    rate_nxt  = rate_full[FRAC_BITS +: COEF_W];
    a2_full   = (COEF_W+RIN_W)'(rate_r) * (COEF_W+RIN_W)'(p4_r.step);
    a2_nxt    = EXP_X_W'(a2_full[FRAC_BITS +: RIN_W]);
  end

  // ---------------- compaction term ----------------
  spd_exp u_exp2 (
    .clk (clk),
    .adv (adv),
    .x   (a2_r),
    .e   (e2)
  );

  // relaxed density toward the maximum; e2 lines up with the delay line tail
  always_comb begin
    delta_full = (DENS_W+EXP_E_W+1)'(d2_r[EXP_LAT-1].diff) * (DENS_W+EXP_E_W+1)'(e2)
               + (DENS_W+EXP_E_W+1)'(1 << (FRAC_BITS - 1));
    delta_nxt  = delta_full[FRAC_BITS +: DENS_W];
    comp_nxt   = q1_r.dneg ? (max_r + delta_r) : (max_r - delta_r);
  end

  // mass-weighted numerator
  always_comb begin
    q3_nxt.valid  = q2_r.valid;
    q3_nxt.prod_a = (WE_W+DENS_W)'(q2_r.swe) * (WE_W+DENS_W)'(comp_r);
    q3_nxt.prod_b = (WE_W+DENS_W)'(q2_r.added) * (WE_W+DENS_W)'(fresh_r);
    q3_nxt.sum    = q2_r.sum;
    q4_nxt.valid  = q3_r.valid;
    q4_nxt.num    = NUM_W'(q3_r.prod_a) + NUM_W'(q3_r.prod_b);
    q4_nxt.den    = q3_r.sum;
  end

  // side data delay lines matched to the exp units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < EXP_LAT; i++) begin
        d1_r[i].valid <= 1'b0;
        d2_r[i].valid <= 1'b0;
      end
      p4_r.valid <= 1'b0;
      p5_r.valid <= 1'b0;
      q1_r.valid <= 1'b0;
      q2_r.valid <= 1'b0;
      q3_r.valid <= 1'b0;
      q4_r.valid <= 1'b0;
    end else if (adv) begin
      d1_r[0] <= p3_r;
      d2_r[0] <= p5_r;
      for (int i = 1; i < EXP_LAT; i++) begin
        d1_r[i] <= d1_r[i-1];
        d2_r[i] <= d2_r[i-1];
      end
      p4_r    <= d1_r[EXP_LAT-1];
      rate_r  <= rate_nxt;
      p5_r    <= p4_r;
      a2_r    <= a2_nxt;
      q1_r    <= d2_r[EXP_LAT-1];
      delta_r <= delta_nxt;
      q2_r    <= q1_r;
      comp_r  <= comp_nxt;
      q3_r    <= q3_nxt;
      q4_r    <= q4_nxt;
    end
  end

  // ---------------- division ----------------
  spd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .din   (q4_r),
    .dout  (dq)
  );

  // saturation, bare ground and clamps
  always_comb begin
    sat_nxt     = dq.den[SUM_W-1];
    swe_out_nxt = sat_nxt ? '1 : dq.den[WE_W-1:0];
    bare_nxt    = dq.den == '0;
    dsel        = bare_nxt ? QUO_W'(fresh_r) : dq.quo;
    dmax        = (dsel > QUO_W'(max_r)) ? QUO_W'(max_r) : dsel;
    dens_nxt    = (dmax < QUO_W'(fresh_r)) ? fresh_r : dmax[DENS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dq.valid;
      swe_out_r   <= swe_out_nxt;
      dens_r      <= dens_nxt;
      sat_r       <= sat_nxt;
      bare_r      <= bare_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_new_water_equiv = swe_out_r;
  assign out_new_density     = dens_r;
  assign out_mass_saturated  = sat_r;
  assign out_bare_ground     = bare_r;

endmodule

/* hdl/spd_checker.sv */
// Port-level checker for the snowpack density update block, with its bind
`include "snowpack_density_update_assert.svh"

module spd_checker import spd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WE_W-1:0]   out_new_water_equiv,
  input logic [DENS_W-1:0] out_new_density,
  input logic              out_mass_saturated,
  input logic              out_bare_ground
);

  // a held result stays offered
  `SPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // a held result keeps its payload
  `SPD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_new_density) && $stable(out_new_water_equiv), "result changed while stalled")

  // a taken result always frees the input side
  `SPD_ASSERT_ALWAYS(a_in_ready, !out_ready || in_ready, "input stalled with output draining")

  // bare ground means no mass and no overflow
  `SPD_ASSERT_ALWAYS(a_bare, !(out_valid && out_bare_ground) || (out_new_water_equiv == '0 && !out_mass_saturated), "bare ground with mass")

  // overflow reports the saturated mass
  `SPD_ASSERT_ALWAYS(a_sat, !(out_valid && out_mass_saturated) || (out_new_water_equiv == '1), "saturation flag without full mass")

endmodule

bind snowpack_density_update spd_checker u_chk (.*);

/* tb/sv/snowpack_density_update_test.sv */
// Self-checking testbench for the snowpack density update pipeline
`timescale 1ns / 1ps

module snowpack_density_update_test;
  import spd_pkg::*;

  typedef struct packed {
    logic [RIN_W-1:0]  snow;
    logic [RIN_W-1:0]  step;
    logic [TEMP_W-1:0] temp;
    logic [WE_W-1:0]   swe;
    logic [DENS_W-1:0] rho;
  } cell_t;

  typedef struct packed {
    logic [WE_W-1:0]   swe;
    logic [DENS_W-1:0] dens;
    logic              sat;
    logic              bare;
  } update_t;

  typedef struct packed {
    logic    typed;
    cell_t   stim;
    update_t upd;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [RIN_W-1:0]  in_snowfall_rate;
  logic [RIN_W-1:0]  in_step_days;
  logic [TEMP_W-1:0] in_skin_temp_kelvin;
  logic [WE_W-1:0]   in_old_water_equiv;
  logic [DENS_W-1:0] in_old_density;
  logic              out_valid;
  logic              out_ready;
  logic [WE_W-1:0]   out_new_water_equiv;
  logic [DENS_W-1:0] out_new_density;
  logic              out_mass_saturated;
  logic              out_bare_ground;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [3:0]        cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  snowpack_density_update dut (.*);

  // predictor copy of the registers
  logic [DENS_W-1:0] fresh_q, max_q;
  logic [COEF_W-1:0] sens_q, base_q;

  update_t pending_updates[$];
  int      errors;
  int      idle_cycles;
  int      hold_cycles;
  int      rx_stall;
  bit      calm;

  localparam int WATCHDOG = 20000;

  // clock, 12 ns
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // exp(-x), x in Q.16; zero beyond 16
  function automatic logic [63:0] decay(logic [63:0] x);
    logic [63:0] y, term, pos, neg, r;
    if (x > (64'd16 << FRAC_BITS)) return 64'd0;
    y = (x << (WORK_BITS - FRAC_BITS)) >> 5;
    term = 64'd1 << WORK_BITS;
    pos = term;
    neg = 64'd0;
    for (int k = 1; k <= TERMS; k++) begin
      term = ((term * y) >> WORK_BITS) / k;
      if (k % 2 == 1) neg += term;
      else pos += term;
    end
    r = pos - neg;
    for (int k = 0; k < SQUARES; k++)
      r = (r * r + (64'd1 << (WORK_BITS - 1))) >> WORK_BITS;
    return (r + (64'd1 << (WORK_BITS - FRAC_BITS - 1))) >> (WORK_BITS - FRAC_BITS);
  endfunction

  // compaction and mass-weighted density for one cell
  function automatic update_t density_update(cell_t c);
    update_t u;
    logic [63:0] rho, tmag, rate, e2, diff, delta, comp, added, sum, dens;
    logic [63:0] half;
    half = 64'd1 << (FRAC_BITS - 1);
    rho = (c.rho < fresh_q) ? fresh_q : c.rho;
    tmag = (c.temp < KELVIN_Q8) ? (KELVIN_Q8 - c.temp) : 64'd0;
    rate = (base_q * decay((sens_q * tmag + 64'd128) >> 8) + half) >> FRAC_BITS;
    e2 = decay((rate * c.step) >> FRAC_BITS);
    if (max_q >= rho) begin
      diff = max_q - rho;
      delta = (diff * e2 + half) >> FRAC_BITS;
      comp = max_q - delta;
    end else begin
      diff = rho - max_q;
      delta = (diff * e2 + half) >> FRAC_BITS;
      comp = max_q + delta;
    end
    added = (c.snow * c.step) >> FRAC_BITS;
    sum = c.swe + added;
    u.sat = sum > 64'hFFFF_FFFF;
    u.swe = u.sat ? 32'hFFFF_FFFF : sum[31:0];
    u.bare = (sum == 0);
    dens = u.bare ? fresh_q : (c.swe * comp + added * fresh_q) / sum;
    if (dens > max_q) dens = max_q;
    if (dens < fresh_q) dens = fresh_q;
    u.dens = dens[DENS_W-1:0];
    return u;
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
  endfunction

  // result side: random stalls plus the long hold-off
  always @(posedge clk) begin
    logic nxt;
    if (!rst_n) begin
      nxt = 1'b0;
      rx_stall = 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      nxt = 1'b0;
    end else begin
      if (out_valid && out_ready) rx_stall = draw_wait();
      if (rx_stall > 0) begin
        rx_stall--;
        nxt = 1'b0;
      end else nxt = 1'b1;
    end
    out_ready <= nxt;
  end

  // result checker
  always @(posedge clk) begin
    update_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected result we=%0d dens=%0d", $time,
                 out_new_water_equiv, out_new_density);
        errors++;
      end else begin
        want = pending_updates.pop_front();
        if (out_new_water_equiv !== want.swe) begin
          $display("%0t: water_equiv expected %0d got %0d", $time, want.swe,
                   out_new_water_equiv);
          errors++;
        end
        if (out_new_density !== want.dens) begin
          $display("%0t: density expected %0d got %0d", $time, want.dens,
                   out_new_density);
          errors++;
        end
        if (out_mass_saturated !== want.sat) begin
          $display("%0t: mass_saturated expected %0b got %0b", $time, want.sat,
                   out_mass_saturated);
          errors++;
        end
        if (out_bare_ground !== want.bare) begin
          $display("%0t: bare_ground expected %0b got %0b", $time, want.bare,
                   out_bare_ground);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("snowpack_density_update: mismatch");
      $finish;
    end
  end

  // register write: setup then access
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_FRESH: fresh_q = val[DENS_W-1:0];
      REG_MAX:   max_q = val[DENS_W-1:0];
      REG_SENS:  sens_q = val[COEF_W-1:0];
      REG_BASE:  base_q = val[COEF_W-1:0];
    endcase
  endtask

  task automatic write_all(logic [31:0] fr, logic [31:0] mx, logic [31:0] se,
                           logic [31:0] ba);
    write_reg(REG_FRESH, fr);
    write_reg(REG_MAX, mx);
    write_reg(REG_SENS, se);
    write_reg(REG_BASE, ba);
  endtask

  // offer one cell, hold until transfer, queue its expectation
  task automatic send_cell(cell_t c, bit typed, update_t known);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_snowfall_rate <= c.snow;
    in_step_days <= c.step;
    in_skin_temp_kelvin <= c.temp;
    in_old_water_equiv <= c.swe;
    in_old_density <= c.rho;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_updates.push_back(typed ? known : density_update(c));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  function automatic cell_t random_cell();
    cell_t c;
    int kind;
    kind = $urandom_range(0, 9);
    c.snow = $urandom;
    c.step = $urandom;
    c.temp = $urandom;
    c.swe = $urandom;
    c.rho = $urandom;
    if (kind < 6) begin
      // plausible cell: short steps, temperatures around freezing
      c.snow = $urandom_range(0, 50 << 16);
      c.step = $urandom_range(0, 8 << 16);
      c.temp = $urandom_range(240 << 8, 290 << 8);
      c.swe = $urandom_range(0, 2000 << 16);
      c.rho = $urandom_range(50 << 16, 700 << 16);
    end else if (kind == 6) begin
      c.swe = $urandom_range(0, 3) == 0 ? 32'd0 : 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
      if ($urandom_range(0, 1) == 0) c.snow = 0;
    end
    return c;
  endfunction

  row_t directed[14];
  update_t none;

  initial begin
    cell_t c;
    errors = 0;
    hold_cycles = 0;
    calm = 1'b0;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_snowfall_rate = '0;
    in_step_days = '0;
    in_skin_temp_kelvin = '0;
    in_old_water_equiv = '0;
    in_old_density = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    fresh_q = 26'd6553600;
    max_q = 26'd19660800;
    sens_q = 16'd5243;
    base_q = 16'd6554;

    // directed cells at reset settings; typed rows are bare ground
    directed = '{
      '{1'b1, '{24'd0, 24'd0, 17'd0, 32'd0, 26'd0}, '{32'd0, 26'd6553600, 1'b0, 1'b1}},
      '{1'b1, '{24'hFFFFFF, 24'd0, 17'd69926, 32'd0, 26'h3FFFFFF},
              '{32'd0, 26'd6553600, 1'b0, 1'b1}},
      '{1'b1, '{24'd0, 24'hFFFFFF, 17'h1FFFF, 32'd0, 26'd0},
              '{32'd0, 26'd6553600, 1'b0, 1'b1}},
      '{1'b0, '{24'hFFFFFF, 24'hFFFFFF, 17'd0, 32'hFFFFFFFF, 26'h3FFFFFF}, '0},
      '{1'b0, '{24'd0, 24'hFFFFFF, 17'd0, 32'hFFFFFFFF, 26'd0}, '0},
      '{1'b0, '{24'd65536, 24'd65536, 17'h1FFFF, 32'd6553600, 26'd9830400}, '0},
      '{1'b0, '{24'd65536, 24'd65536, 17'd69926, 32'd6553600, 26'd9830400}, '0},
      '{1'b0, '{24'd65536, 24'd65536, 17'd69925, 32'd6553600, 26'd9830400}, '0},
      '{1'b0, '{24'd655360, 24'd65536, 17'd68608, 32'd6553600, 26'd9830400}, '0},
      '{1'b0, '{24'd0, 24'hFFFFFF, 17'd0, 32'd6553600, 26'h3FFFFFF}, '0},
      '{1'b0, '{24'd0, 24'd327680, 17'd65536, 32'd1, 26'd0}, '0},
      '{1'b0, '{24'hFFFFFF, 24'd1, 17'd70000, 32'd0, 26'd9830400}, '0},
      '{1'b0, '{24'd1, 24'd1, 17'd60000, 32'hFFFFFFFE, 26'd30000000}, '0},
      '{1'b0, '{24'hAAAAAA, 24'h555555, 17'h15555, 32'hAAAAAAAA, 26'h1555555}, '0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_cell(directed[i].stim, directed[i].typed, directed[i].upd);
    drain();

    // register settings: extremes, inverted limits, reset defaults, then random
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: write_all(0, 32'h3FFFFFF, 32'hFFFF, 32'hFFFF);
        1: write_all(32'h3FFFFFF, 0, 0, 0);
        2: write_all(6553600, 19660800, 5243, 6554);
        default: write_all(
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(30 << 16, 200 << 16),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(200 << 16, 700 << 16),
                   $urandom, $urandom);
      endcase
      calm = (phase == 4);
      if (phase == 3) hold_cycles = 400;
      for (int n = 0; n < 205; n++) begin
        c = random_cell();
        send_cell(c, 1'b0, none);
      end
      drain();
    end

    calm = 1'b0;
    repeat (150) @(posedge clk);
    if (errors == 0) $display("snowpack_density_update: match");
    else $display("snowpack_density_update: mismatch");
    $finish;
  end

endmodule
